// File: rtl/aslw_pkg.sv
// Package for the antialiased styled line walker: payload structs, walk modes,
// style codes and the queue entry between front and back. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package aslw_pkg;

	localparam int CoordBits = 16;
	localparam int AccBits = 32;
	localparam int WeightBits = 8;
	localparam int LevelBits = 9;
	localparam int SpanBits = 17;

	typedef enum logic [1:0] {
		STYLE_SOLID = 2'd0,
		STYLE_DASHED = 2'd1,
		STYLE_DOTTED = 2'd2,
		STYLE_DASHDOT = 2'd3
	} style_t;

	typedef enum logic [2:0] {
		M_IDLE = 3'd0,
		M_HORIZ = 3'd1,
		M_VERT = 3'd2,
		M_DIAG = 3'd3,
		M_XMAJ = 3'd4,
		M_YMAJ = 3'd5,
		M_ENDPT = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		F_IDLE = 2'd0,
		F_DIV = 2'd1,
		F_PUSH = 2'd2
	} fstate_t;

	typedef struct packed {
		logic func;
		logic signed [CoordBits-1:0] start_x;
		logic signed [CoordBits-1:0] start_y;
		logic signed [CoordBits-1:0] end_x;
		logic signed [CoordBits-1:0] end_y;
		logic draw_end;
	} in_item_t;

	typedef struct packed {
		logic main_valid;
		logic signed [CoordBits-1:0] main_x;
		logic signed [CoordBits-1:0] main_y;
		logic [LevelBits-1:0] main_level;
		logic pair_valid;
		logic signed [CoordBits-1:0] pair_x;
		logic signed [CoordBits-1:0] pair_y;
		logic [LevelBits-1:0] pair_level;
		logic line_done;
	} out_item_t;

	// Classified command handed from the front to the back.
	typedef struct packed {
		logic is_start;
		mode_t mode;
		logic signed [CoordBits-1:0] x0;
		logic signed [CoordBits-1:0] y0;
		logic signed [CoordBits-1:0] x1;
		logic signed [CoordBits-1:0] y1;
		logic x_neg;
		logic y_neg;
		logic [SpanBits-1:0] steps;
		logic [AccBits-1:0] err_step;
		logic want_end;
	} cmd_t;

endpackage
`default_nettype wire

// File: rtl/antialiased_styled_line_walker_core.sv
// Top level of the antialiased styled line walker: front end, command queue
// and walker. Uses aslw_pkg, aslw_front, aslw_queue and aslw_back.
`timescale 1ns / 1ps
`default_nettype none
// A start transaction is registered in the front end, pushed into the queue
// and taken by the walker, whose output register gives the start pixel;
// x-major and y-major lines first pass the restoring divider (one numerator
// bit per cycle). The front end takes one transaction at a time, and the next
// only once the last is pushed; the walker emits one pixel group per cycle
// unless stalled. Writing the line style also restarts the dash pattern.
module antialiased_styled_line_walker_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire aslw_pkg::in_item_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output aslw_pkg::out_item_t out_data,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [1:0] cfg_data
);

	logic f_valid, f_ready, q_valid, q_ready;
	aslw_pkg::cmd_t f_cmd, q_cmd;

	assign cfg_ready = 1'b1;

	aslw_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
	);

	aslw_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
	);

	aslw_back u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
		.cfg_valid(cfg_valid), .cfg_style(aslw_pkg::style_t'(cfg_data)),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

endmodule
`default_nettype wire

// File: rtl/aslw_front.sv
// Front end: accepts input transactions, classifies lines and runs the
// restoring divider for the error increment. Uses aslw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module aslw_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire aslw_pkg::in_item_t in_data,
	output logic cmd_valid,
	input wire logic cmd_ready,
	output aslw_pkg::cmd_t cmd
);

	localparam int AB = aslw_pkg::AccBits;
	localparam int SB = aslw_pkg::SpanBits;

	aslw_pkg::fstate_t state_q, state_d;
	aslw_pkg::cmd_t cmd_q;
	logic [SB-1:0] div_den_q;
	logic [SB:0] rem_q;
	logic [SB-1+AB:0] num_q;
	logic [AB-1:0] quo_q;
	logic [5:0] cnt_q;

	logic [SB-1:0] dx, dy;
	logic xn, yn;
	aslw_pkg::cmd_t cls;
	logic [SB:0] rem_sh;
	logic ge;

	always_comb begin
		xn = in_data.end_x < in_data.start_x;
		yn = in_data.end_y < in_data.start_y;
		dx = xn ? SB'(17'(signed'(in_data.start_x)) - 17'(signed'(in_data.end_x)))
			: SB'(17'(signed'(in_data.end_x)) - 17'(signed'(in_data.start_x)));
		dy = yn ? SB'(17'(signed'(in_data.start_y)) - 17'(signed'(in_data.end_y)))
			: SB'(17'(signed'(in_data.end_y)) - 17'(signed'(in_data.start_y)));
		cls = '0;
		cls.is_start = !in_data.func;
		cls.x0 = in_data.start_x;
		cls.y0 = in_data.start_y;
		cls.x1 = in_data.end_x;
		cls.y1 = in_data.end_y;
		cls.x_neg = xn;
		cls.y_neg = yn;
		cls.want_end = in_data.draw_end;
		if (dx == '0 && dy == '0) begin
			cls.mode = aslw_pkg::M_IDLE;
		end else if (dy == '0) begin
			cls.mode = aslw_pkg::M_HORIZ;
			cls.steps = dx;
		end else if (dx == '0) begin
			cls.mode = aslw_pkg::M_VERT;
			cls.steps = dy;
		end else if (dx == dy) begin
			cls.mode = aslw_pkg::M_DIAG;
			cls.steps = dy;
		end else if (dy > dx) begin
			cls.mode = aslw_pkg::M_YMAJ;
			cls.steps = dy - 1'b1;
		end else begin
			cls.mode = aslw_pkg::M_XMAJ;
			cls.steps = dx - 1'b1;
		end
	end

	assign rem_sh = {rem_q[SB-1:0], num_q[SB-1+AB]};
	assign ge = rem_sh >= {1'b0, div_den_q};

	always_comb begin
		state_d = state_q;
		in_stall = 1'b1;
		cmd_valid = 1'b0;
		case (state_q)
			aslw_pkg::F_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (in_data.func == 1'b0 &&
						(cls.mode == aslw_pkg::M_XMAJ || cls.mode == aslw_pkg::M_YMAJ))
						state_d = aslw_pkg::F_DIV;
					else
						state_d = aslw_pkg::F_PUSH;
				end
			end
			aslw_pkg::F_DIV: begin
				if (cnt_q == 6'(SB + AB - 1)) state_d = aslw_pkg::F_PUSH;
			end
			aslw_pkg::F_PUSH: begin
				cmd_valid = 1'b1;
				if (cmd_ready) state_d = aslw_pkg::F_IDLE;
			end
			default: state_d = aslw_pkg::F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aslw_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// One quotient bit per cycle; the numerator is minor << 32 over major.
	always_ff @(posedge clk) begin
		if (state_q == aslw_pkg::F_IDLE && in_valid) begin
			cmd_q <= cls;
			cnt_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			if (cls.mode == aslw_pkg::M_YMAJ) begin
				num_q <= {dx, {AB{1'b0}}};
				div_den_q <= dy;
			end else begin
				num_q <= {dy, {AB{1'b0}}};
				div_den_q <= dx;
			end
		end else if (state_q == aslw_pkg::F_DIV) begin
			num_q <= {num_q[SB-2+AB:0], 1'b0};
			rem_q <= ge ? rem_sh - {1'b0, div_den_q} : rem_sh;
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q >= 6'(SB)) quo_q <= {quo_q[AB-2:0], ge};
			if (cnt_q == 6'(SB + AB - 1)) begin
				cmd_q.err_step <= {quo_q[AB-2:0], ge};
			end
		end
	end

	// The divider runs SB + AB bits in total; the count is widened accordingly.
	assign cmd = cmd_q;

endmodule
`default_nettype wire

// File: rtl/aslw_queue.sv
// Two-entry queue between the front end and the walker. Uses aslw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module aslw_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_valid,
	output logic wr_ready,
	input wire aslw_pkg::cmd_t wr_data,
	output logic rd_valid,
	input wire logic rd_ready,
	output aslw_pkg::cmd_t rd_data
);

	aslw_pkg::cmd_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end

endmodule
`default_nettype wire

// File: rtl/aslw_back.sv
// Back end: walks the line one pixel group per command, applies the pen
// style and holds the output register. Uses aslw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module aslw_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	output logic cmd_ready,
	input wire aslw_pkg::cmd_t cmd,
	input wire logic cfg_valid,
	input wire aslw_pkg::style_t cfg_style,
	output logic out_valid,
	input wire logic out_stall,
	output aslw_pkg::out_item_t out_data
);

	localparam int CB = aslw_pkg::CoordBits;
	localparam int AB = aslw_pkg::AccBits;
	localparam int WB = aslw_pkg::WeightBits;
	localparam int LB = aslw_pkg::LevelBits;
	localparam int SB = aslw_pkg::SpanBits;

	aslw_pkg::style_t style_q;
	logic [3:0] pen_q;
	logic signed [CB-1:0] cur_x_q, cur_y_q, last_x_q, last_y_q;
	logic x_neg_q, y_neg_q, want_end_q;
	logic [SB-1:0] steps_q;
	logic [AB-1:0] acc_q, estep_q;
	aslw_pkg::mode_t mode_q;
	logic out_valid_q;
	aslw_pkg::out_item_t out_q;

	logic fire, pen_on, pen_adv;
	aslw_pkg::out_item_t res;
	logic signed [CB-1:0] sx, sy, nx, ny;
	logic [AB-1:0] nacc;
	logic [WB-1:0] w;
	logic [SB-1:0] nsteps;
	aslw_pkg::mode_t nmode;

	assign cmd_ready = !out_valid_q || !out_stall;
	assign fire = cmd_valid && cmd_ready;

	always_comb begin
		case (style_q)
			aslw_pkg::STYLE_SOLID: pen_on = 1'b1;
			aslw_pkg::STYLE_DASHED: pen_on = pen_q[2];
			aslw_pkg::STYLE_DOTTED: pen_on = pen_q[1];
			aslw_pkg::STYLE_DASHDOT: pen_on = pen_q < 4'd6 || (pen_q >= 4'd10 && pen_q < 4'd12);
			default: pen_on = 1'b1;
		endcase
	end

	always_comb begin
		sx = x_neg_q ? -CB'(1) : CB'(1);
		sy = y_neg_q ? -CB'(1) : CB'(1);
		nx = cur_x_q;
		ny = cur_y_q;
		nacc = acc_q + estep_q;
		w = nacc[AB-1 -: WB];
		nsteps = steps_q;
		nmode = mode_q;
		pen_adv = 1'b1;
		res = '0;
		if (cmd.is_start) begin
			res.main_valid = pen_on;
			res.main_x = cmd.x0;
			res.main_y = cmd.y0;
			res.main_level = LB'(256);
			res.line_done = cmd.mode == aslw_pkg::M_IDLE;
		end else begin
			case (mode_q)
				aslw_pkg::M_HORIZ, aslw_pkg::M_VERT, aslw_pkg::M_DIAG,
				aslw_pkg::M_XMAJ, aslw_pkg::M_YMAJ: begin
					case (mode_q)
						aslw_pkg::M_HORIZ: nx = cur_x_q + sx;
						aslw_pkg::M_VERT: ny = cur_y_q + sy;
						aslw_pkg::M_DIAG: begin
							nx = cur_x_q + sx;
							ny = cur_y_q + sy;
						end
						aslw_pkg::M_YMAJ: begin
							if (nacc <= acc_q) nx = cur_x_q + sx;
							ny = cur_y_q + sy;
						end
						default: begin
							if (nacc <= acc_q) ny = cur_y_q + sy;
							nx = cur_x_q + sx;
						end
					endcase
					res.main_valid = pen_on;
					res.main_x = nx;
					res.main_y = ny;
					res.main_level = LB'(256);
					if (mode_q == aslw_pkg::M_XMAJ || mode_q == aslw_pkg::M_YMAJ) begin
						res.main_level = LB'(256) - LB'(w);
						res.pair_level = LB'(w) + 1'b1;
						res.pair_valid = pen_on;
						res.pair_x = (mode_q == aslw_pkg::M_YMAJ) ? nx + sx : nx;
						res.pair_y = (mode_q == aslw_pkg::M_YMAJ) ? ny : ny + sy;
					end
					if (steps_q != '0) nsteps = steps_q - 1'b1;
					if (nsteps == '0) begin
						if (want_end_q) nmode = aslw_pkg::M_ENDPT;
						else begin
							nmode = aslw_pkg::M_IDLE;
							res.line_done = 1'b1;
						end
					end
				end
				aslw_pkg::M_ENDPT: begin
					res.main_valid = pen_on;
					res.main_x = last_x_q;
					res.main_y = last_y_q;
					res.main_level = LB'(256);
					res.line_done = 1'b1;
					nmode = aslw_pkg::M_IDLE;
				end
				default: begin
					res.line_done = 1'b1;
					nmode = aslw_pkg::M_IDLE;
					pen_adv = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			style_q <= aslw_pkg::STYLE_SOLID;
			pen_q <= '0;
			mode_q <= aslw_pkg::M_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				style_q <= cfg_style;
				pen_q <= '0;
			end else if (fire && pen_adv) begin
				pen_q <= pen_q + 1'b1;
			end
			if (fire) begin
				mode_q <= cmd.is_start ? cmd.mode : nmode;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= res;
			if (cmd.is_start) begin
				cur_x_q <= cmd.x0;
				cur_y_q <= cmd.y0;
				last_x_q <= cmd.x1;
				last_y_q <= cmd.y1;
				x_neg_q <= cmd.x_neg;
				y_neg_q <= cmd.y_neg;
				want_end_q <= cmd.want_end;
				steps_q <= cmd.steps;
				acc_q <= '0;
				estep_q <= cmd.err_step;
			end else begin
				cur_x_q <= nx;
				cur_y_q <= ny;
				steps_q <= nsteps;
				if (mode_q == aslw_pkg::M_XMAJ || mode_q == aslw_pkg::M_YMAJ)
					acc_q <= nacc;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule
`default_nettype wire

// File: test/tb_antialiased_styled_line_walker_core.sv
// Testbench for the antialiased styled line walker core: directed and random lines,
// style changes between phases, checked against a built-in walker model.
// Depends on aslw_pkg and antialiased_styled_line_walker_core.
`timescale 1ns / 1ps
class pixel_scoreboard;
	aslw_pkg::out_item_t pending[$];
	int errors;
	aslw_pkg::style_t style;
	logic signed [15:0] cur_x, cur_y, last_x, last_y;
	bit neg_x, neg_y, want_end;
	longint steps_left;
	bit [31:0] acc, acc_step;
	aslw_pkg::mode_t mode;
	bit [3:0] pen;

	function new();
		errors = 0;
		style = aslw_pkg::STYLE_SOLID;
		cur_x = 0; cur_y = 0; last_x = 0; last_y = 0;
		neg_x = 0; neg_y = 0; want_end = 0; steps_left = 0;
		acc = 0; acc_step = 0; mode = aslw_pkg::M_IDLE; pen = 0;
	endfunction

	function void set_style(aslw_pkg::style_t s);
		style = s;
		pen = 0;
	endfunction

	function bit pen_on();
		bit [3:0] q;
		q = pen;
		pen = pen + 4'd1;
		case (style)
			aslw_pkg::STYLE_SOLID: return 1'b1;
			aslw_pkg::STYLE_DASHED: return q[2];
			aslw_pkg::STYLE_DOTTED: return q[1];
			default: return (q < 6) || (q >= 10 && q < 12);
		endcase
	endfunction

	function void note_input(aslw_pkg::in_item_t it);
		aslw_pkg::out_item_t r;
		longint dx, dy;
		bit [63:0] num;
		bit pv, pair;
		logic signed [15:0] sx, sy;
		bit [31:0] prev;
		bit [7:0] w;
		r = '0;
		if (!it.func) begin
			pv = pen_on();
			cur_x = it.start_x; cur_y = it.start_y;
			last_x = it.end_x; last_y = it.end_y;
			want_end = it.draw_end;
			neg_x = it.end_x < it.start_x;
			neg_y = it.end_y < it.start_y;
			dx = neg_x ? longint'(it.start_x) - it.end_x : longint'(it.end_x) - it.start_x;
			dy = neg_y ? longint'(it.start_y) - it.end_y : longint'(it.end_y) - it.start_y;
			acc = 0; acc_step = 0;
			r.main_valid = pv; r.main_x = it.start_x; r.main_y = it.start_y;
			r.main_level = 9'd256;
			if (dx == 0 && dy == 0) begin
				mode = aslw_pkg::M_IDLE; steps_left = 0; r.line_done = 1;
			end else if (dy == 0) begin
				mode = aslw_pkg::M_HORIZ; steps_left = dx;
			end else if (dx == 0) begin
				mode = aslw_pkg::M_VERT; steps_left = dy;
			end else if (dx == dy) begin
				mode = aslw_pkg::M_DIAG; steps_left = dy;
			end else if (dy > dx) begin
				mode = aslw_pkg::M_YMAJ; steps_left = dy - 1;
				num = 64'(dx) << 32; acc_step = 32'(num / 64'(dy));
			end else begin
				mode = aslw_pkg::M_XMAJ; steps_left = dx - 1;
				num = 64'(dy) << 32; acc_step = 32'(num / 64'(dx));
			end
		end else if (mode == aslw_pkg::M_IDLE) begin
			r.line_done = 1;
		end else if (mode == aslw_pkg::M_ENDPT) begin
			r.main_valid = pen_on(); r.main_x = last_x; r.main_y = last_y;
			r.main_level = 9'd256; r.line_done = 1;
			mode = aslw_pkg::M_IDLE;
		end else begin
			sx = neg_x ? -16'sd1 : 16'sd1;
			sy = neg_y ? -16'sd1 : 16'sd1;
			pair = 0;
			r.main_level = 9'd256;
			case (mode)
				aslw_pkg::M_HORIZ: cur_x = cur_x + sx;
				aslw_pkg::M_VERT: cur_y = cur_y + sy;
				aslw_pkg::M_DIAG: begin
					cur_x = cur_x + sx; cur_y = cur_y + sy;
				end
				default: begin
					prev = acc;
					acc = acc + acc_step;
					pair = 1;
					if (mode == aslw_pkg::M_YMAJ) begin
						if (acc <= prev) cur_x = cur_x + sx;
						cur_y = cur_y + sy;
						r.pair_x = cur_x + sx; r.pair_y = cur_y;
					end else begin
						if (acc <= prev) cur_y = cur_y + sy;
						cur_x = cur_x + sx;
						r.pair_x = cur_x; r.pair_y = cur_y + sy;
					end
					w = acc[31:24];
					r.main_level = 9'd256 - w;
					r.pair_level = {1'b0, w} + 9'd1;
				end
			endcase
			pv = pen_on();
			if (steps_left > 0) steps_left--;
			if (steps_left == 0) begin
				if (want_end) mode = aslw_pkg::M_ENDPT;
				else begin
					mode = aslw_pkg::M_IDLE; r.line_done = 1;
				end
			end
			r.main_valid = pv; r.main_x = cur_x; r.main_y = cur_y;
			r.pair_valid = pair && pv;
		end
		pending.insert(pending.size(), r);
	endfunction

	function void check_result(aslw_pkg::out_item_t got);
		aslw_pkg::out_item_t e;
		if (pending.size() == 0) begin
			$error("unexpected result %h", got);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (got.main_valid !== e.main_valid) begin
			$error("main_valid exp %0d got %0d", e.main_valid, got.main_valid); errors++;
		end
		if (got.main_x !== e.main_x) begin
			$error("main_x exp %0d got %0d", e.main_x, got.main_x); errors++;
		end
		if (got.main_y !== e.main_y) begin
			$error("main_y exp %0d got %0d", e.main_y, got.main_y); errors++;
		end
		if (got.main_level !== e.main_level) begin
			$error("main_level exp %0d got %0d", e.main_level, got.main_level); errors++;
		end
		if (got.pair_valid !== e.pair_valid) begin
			$error("pair_valid exp %0d got %0d", e.pair_valid, got.pair_valid); errors++;
		end
		if (got.pair_x !== e.pair_x) begin
			$error("pair_x exp %0d got %0d", e.pair_x, got.pair_x); errors++;
		end
		if (got.pair_y !== e.pair_y) begin
			$error("pair_y exp %0d got %0d", e.pair_y, got.pair_y); errors++;
		end
		if (got.pair_level !== e.pair_level) begin
			$error("pair_level exp %0d got %0d", e.pair_level, got.pair_level); errors++;
		end
		if (got.line_done !== e.line_done) begin
			$error("line_done exp %0d got %0d", e.line_done, got.line_done); errors++;
		end
	endfunction
endclass

module tb_antialiased_styled_line_walker_core;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
	aslw_pkg::in_item_t in_data;
	aslw_pkg::out_item_t out_data;
	logic [1:0] cfg_data;
	pixel_scoreboard board;
	int burst_left;

	antialiased_styled_line_walker_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("FAILURE");
		$finish;
	end

	// Receiver stalls in runs; a random mode picks calm or busy stretches.
	int stall_mode;
	always @(posedge clk) begin
		if (out_valid && !out_stall && arst_n) board.check_result(out_data);
		if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 1) == 0);
		endcase
	end

	task automatic send_line(input aslw_pkg::in_item_t it);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 20);
		end
		in_data <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		board.note_input(it);
		burst_left--;
		if (burst_left == 0) in_valid <= 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_style(input aslw_pkg::style_t s);
		cfg_data <= s;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.set_style(s);
	endtask

	function automatic aslw_pkg::in_item_t make_start(int x0, int y0, int x1, int y1, bit de);
		aslw_pkg::in_item_t it;
		it.func = 1'b0;
		it.start_x = 16'(x0); it.start_y = 16'(y0);
		it.end_x = 16'(x1); it.end_y = 16'(y1);
		it.draw_end = de;
		return it;
	endfunction

	function automatic aslw_pkg::in_item_t step_item();
		aslw_pkg::in_item_t it;
		it = aslw_pkg::in_item_t'(66'({$urandom, $urandom}));
		it.func = 1'b1;
		return it;
	endfunction

	task automatic walk(input aslw_pkg::in_item_t st, input int extra);
		send_line(st);
		repeat (extra) send_line(step_item());
	endtask

	function automatic int rnd_coord();
		if ($urandom_range(0, 9) == 0) return $signed(16'($urandom));
		return $urandom_range(0, 80) - 40;
	endfunction

	initial begin
		int n, x0, y0, x1, y1, len;
		board = new();
		stall_mode = 0;
		arst_n = 0; in_valid = 0; in_data = '0; out_stall = 0;
		cfg_valid = 0; cfg_data = aslw_pkg::STYLE_SOLID;
		burst_left = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: idle step, zero length, straight, diagonal, weighted, extremes.
		send_line(step_item());
		walk(make_start(5, 5, 5, 5, 1), 1);
		walk(make_start(0, 0, 4, 0, 1), 6);
		walk(make_start(0, 0, 0, -3, 0), 3);
		walk(make_start(2, 2, -1, -1, 1), 4);
		walk(make_start(0, 0, 7, 3, 1), 8);
		walk(make_start(0, 0, -2, 9, 0), 9);
		walk(make_start(0, 3, 20, 0, 0), 3);
		walk(make_start(-32768, 32767, 32767, -32768, 1), 2);
		walk(make_start(32767, 32767, 32765, 32766, 1), 3);
		drain();

		// The pause below also shows the block idles between styles.
		for (int ph = 0; ph < 6; ph++) begin
			write_style(aslw_pkg::style_t'(ph % 4));
			n = 0;
			while (n < 250) begin
				x0 = rnd_coord(); y0 = rnd_coord();
				case ($urandom_range(0, 4))
					0: begin x1 = x0 + $urandom_range(0, 12) - 6; y1 = y0; end
					1: begin x1 = x0; y1 = y0 + $urandom_range(0, 12) - 6; end
					2: begin
						len = $urandom_range(0, 8);
						x1 = x0 + ($urandom_range(0, 1) ? len : -len);
						y1 = y0 + ($urandom_range(0, 1) ? len : -len);
					end
					default: begin
						x1 = x0 + $urandom_range(0, 30) - 15;
						y1 = y0 + $urandom_range(0, 30) - 15;
					end
				endcase
				if ($urandom_range(0, 15) == 0) x1 = rnd_coord();
				len = $urandom_range(0, 20);
				walk(make_start(x0, y0, x1, y1, $urandom_range(0, 1)), len);
				n += len + 1;
			end
			drain();
		end

		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule

// File: files.f
rtl/aslw_pkg.sv
rtl/aslw_front.sv
rtl/aslw_queue.sv
rtl/aslw_back.sv
rtl/antialiased_styled_line_walker_core.sv
test/tb_antialiased_styled_line_walker_core.sv
